FILE: hw/rtl/fltm_pkg.sv
// Package: shared types, widths and datapath command codes for the term unit.
`timescale 1ns / 1ps
`default_nettype none
package fltm_pkg;

    localparam int MOD_BITS  = 31;
    localparam int IDX_BITS  = 31;
    localparam int SEED_BITS = 63;
    localparam int PROD_BITS = 2 * MOD_BITS;

    typedef struct packed {
        logic [SEED_BITS-1:0] first_seed;
        logic [SEED_BITS-1:0] second_seed;
        logic [IDX_BITS-1:0]  term_index;
    } fltm_in_t;

    typedef struct packed {
        logic [MOD_BITS-1:0] term_value;
        logic                bad_index;
    } fltm_out_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_G1,
        OP_RED_G2,
        OP_INIT,
        OP_MUL_ACC,
        OP_MUL_SQR,
        OP_DIFF,
        OP_FINAL
    } fltm_op_t;

    typedef struct packed {
        fltm_op_t op;
        logic     start;
    } fltm_cmd_t;

    typedef struct packed {
        logic                 busy;
        logic                 exp_bit;
        logic                 exp_zero;
        logic                 idx_zero;
    } fltm_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fltm_modred.sv
// Sequential restoring reduction: value mod m, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fltm_modred
    import fltm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [SEED_BITS:0]   dividend,
    input  wire logic [MOD_BITS-1:0]  modulus,
    output logic                      done,
    output logic [MOD_BITS-1:0]       remainder
);

    localparam int DW = SEED_BITS + 1;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [MOD_BITS:0] rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [MOD_BITS+1:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DW-1]} - {2'b00, modulus};
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = CW'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (!trial[MOD_BITS+1])
                rem_next = trial[MOD_BITS:0];
            else
                rem_next = {rem_reg[MOD_BITS-1:0], dvd_reg[DW-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[MOD_BITS-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/fltm_datapath.sv
// Datapath: matrix registers, one multiplier, one shared modular reducer.
`timescale 1ns / 1ps
`default_nettype none
module fltm_datapath
    import fltm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fltm_cmd_t            cmd,
    input  wire fltm_in_t             item,
    input  wire logic [MOD_BITS-1:0]  modulus,
    output fltm_stat_t                stat,
    output logic [MOD_BITS-1:0]       result
);

    // micro-step sequencer inside one command; each step is one reduction
    logic [MOD_BITS-1:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic [MOD_BITS-1:0] b00_reg, b01_reg, b10_reg, b11_reg;
    logic [MOD_BITS-1:0] g1_reg, g2_reg, t_reg, r_reg;
    logic [MOD_BITS-1:0] n00_reg, n01_reg, n10_reg;
    logic [IDX_BITS-1:0] exp_reg;
    logic                idz_reg;
    fltm_op_t            op_reg;
    logic [3:0]          step_reg;
    logic                busy_reg, wait_reg;

    logic [SEED_BITS:0]  red_in;
    logic                red_start, red_done;
    logic [MOD_BITS-1:0] red_out;
    logic [MOD_BITS-1:0] mx, my;
    logic [PROD_BITS-1:0] prod_reg;
    logic                prod_ph_reg;

    fltm_modred u_red (
        .clk(clk), .rst_n(rst_n), .start(red_start), .dividend(red_in),
        .modulus(modulus), .done(red_done), .remainder(red_out)
    );

    // operand selection for step: even steps are products, odd steps are sums
    always_comb
    begin
        mx = '0;
        my = '0;
        case (op_reg)
            OP_MUL_ACC, OP_MUL_SQR:
            begin
                // products: element (i,j) = a_i0*b_0j + a_i1*b_1j; X = acc or base
                case (step_reg[3:1])
                    3'd0: begin mx = (op_reg == OP_MUL_ACC) ? a00_reg : b00_reg; my = b00_reg; end
                    3'd1: begin mx = (op_reg == OP_MUL_ACC) ? a01_reg : b01_reg; my = b10_reg; end
                    3'd2: begin mx = (op_reg == OP_MUL_ACC) ? a00_reg : b00_reg; my = b01_reg; end
                    3'd3: begin mx = (op_reg == OP_MUL_ACC) ? a01_reg : b01_reg; my = b11_reg; end
                    3'd4: begin mx = (op_reg == OP_MUL_ACC) ? a10_reg : b10_reg; my = b00_reg; end
                    3'd5: begin mx = (op_reg == OP_MUL_ACC) ? a11_reg : b11_reg; my = b10_reg; end
                    3'd6: begin mx = (op_reg == OP_MUL_ACC) ? a10_reg : b10_reg; my = b01_reg; end
                    default: begin mx = (op_reg == OP_MUL_ACC) ? a11_reg : b11_reg; my = b11_reg; end
                endcase
            end
            OP_FINAL:
            begin
                mx = step_reg[1] ? a01_reg : a00_reg;
                my = step_reg[1] ? t_reg : g1_reg;
            end
            default: ;
        endcase
    end

    // steps: even steps reduce a product, odd steps reduce r + that remainder
    logic sum_step;
    assign sum_step = step_reg[0];

    always_comb
    begin
        red_in = '0;
        case (op_reg)
            OP_RED_G1: red_in = {1'b0, item.first_seed};
            OP_RED_G2: red_in = {1'b0, item.second_seed};
            OP_DIFF:   red_in = (SEED_BITS+1)'({1'b0, modulus} + {1'b0, g2_reg}
                                               - {1'b0, g1_reg});
            OP_INIT:   red_in = (SEED_BITS+1)'(1);
            default:
                if (sum_step)
                    red_in = (SEED_BITS+1)'({1'b0, r_reg} + {1'b0, red_out});
                else
                    red_in = (SEED_BITS+1)'(prod_reg);
        endcase
    end

    assign red_start = busy_reg && !wait_reg && !prod_ph_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mx * my;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            wait_reg    <= 1'b0;
            prod_ph_reg <= 1'b0;
            op_reg      <= OP_NONE;
            step_reg    <= '0;
        end
        else if (cmd.start && !busy_reg)
        begin
            op_reg   <= cmd.op;
            step_reg <= '0;
            if (cmd.op == OP_LOAD)
                busy_reg <= 1'b0;
            else
            begin
                busy_reg    <= 1'b1;
                prod_ph_reg <= (cmd.op == OP_MUL_ACC || cmd.op == OP_MUL_SQR
                                || cmd.op == OP_FINAL);
                wait_reg    <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (prod_ph_reg)
                prod_ph_reg <= 1'b0;
            else if (!wait_reg)
                wait_reg <= 1'b1;
            else if (red_done)
            begin
                wait_reg <= 1'b0;
                case (op_reg)
                    OP_MUL_ACC, OP_MUL_SQR:
                    begin
                        if (step_reg == 4'd15)
                            busy_reg <= 1'b0;
                        else
                        begin
                            step_reg    <= step_reg + 1'b1;
                            // every following step, product or sum, starts with a multiply phase
                            prod_ph_reg <= 1'b1;
                        end
                    end
                    OP_FINAL:
                    begin
                        if (step_reg == 4'd3)
                            busy_reg <= 1'b0;
                        else
                        begin
                            step_reg    <= step_reg + 1'b1;
                            prod_ph_reg <= 1'b1;
                        end
                    end
                    default: busy_reg <= 1'b0;
                endcase
            end
        end
    end

    // per element: 0 reduce first product, 1 r = 0 + it, 2 reduce second
    // product, 3 element = r + it; the reducer output holds between steps
    always_ff @(posedge clk)
    begin
        if (cmd.start && !busy_reg)
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    exp_reg <= item.term_index - 1'b1;
                    idz_reg <= (item.term_index == '0);
                end
                OP_MUL_SQR: ;
                default: ;
            endcase
            r_reg <= '0;
        end
        else if (busy_reg && wait_reg && red_done)
        begin
            case (op_reg)
                OP_RED_G1:
                begin
                    // also the answer for a zero index
                    g1_reg <= red_out;
                    result <= red_out;
                end
                OP_RED_G2: g2_reg <= red_out;
                OP_DIFF:   t_reg  <= red_out;
                OP_INIT:
                begin
                    a00_reg <= red_out; a01_reg <= '0; a10_reg <= '0; a11_reg <= red_out;
                    b00_reg <= red_out; b01_reg <= red_out; b10_reg <= red_out;
                    b11_reg <= '0;
                end
                OP_MUL_ACC, OP_MUL_SQR, OP_FINAL:
                begin
                    if (sum_step && !step_reg[1])
                        r_reg <= red_out;
                    else if (sum_step)
                    begin
                        // red_out is now the reduced sum of both products
                        r_reg <= '0;
                        if (op_reg == OP_FINAL)
                            result <= red_out;
                        else
                        begin
                            case (step_reg[3:2])
                                2'd0: n00_reg <= red_out;
                                2'd1: n01_reg <= red_out;
                                2'd2: n10_reg <= red_out;
                                default:
                                begin
                                    if (op_reg == OP_MUL_ACC)
                                    begin
                                        a00_reg <= n00_reg; a01_reg <= n01_reg;
                                        a10_reg <= n10_reg; a11_reg <= red_out;
                                    end
                                    else
                                    begin
                                        b00_reg <= n00_reg; b01_reg <= n01_reg;
                                        b10_reg <= n10_reg; b11_reg <= red_out;
                                        exp_reg <= exp_reg >> 1;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.exp_bit  = exp_reg[0];
    assign stat.exp_zero = (exp_reg == '0);
    assign stat.idx_zero = idz_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/fltm_ctrl.sv
// Controller: sequences datapath commands for one transaction.
`timescale 1ns / 1ps
`default_nettype none
module fltm_ctrl
    import fltm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic       out_taken,
    input  wire fltm_stat_t stat,
    output fltm_cmd_t       cmd,
    output logic            idle,
    output logic            result_valid
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RG1   = 9'b000000010,
        S_RG2   = 9'b000000100,
        S_INIT  = 9'b000001000,
        S_LOOP  = 9'b000010000,
        S_SQR   = 9'b000100000,
        S_DIFF  = 9'b001000000,
        S_FINAL = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        cmd.start   = 1'b0;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_LOAD;
                    state_next = S_RG1;
                end
            end
            S_OUT:
                if (out_taken)
                    state_next = S_IDLE;
            default:
            begin
                if (!issued_reg)
                begin
                    cmd.start   = 1'b1;
                    issued_next = 1'b1;
                    case (state_reg)
                        S_RG1:   cmd.op = OP_RED_G1;
                        S_RG2:   cmd.op = OP_RED_G2;
                        S_INIT:  cmd.op = OP_INIT;
                        S_LOOP:  cmd.op = OP_MUL_ACC;
                        S_SQR:   cmd.op = OP_MUL_SQR;
                        S_DIFF:  cmd.op = OP_DIFF;
                        default: cmd.op = OP_FINAL;
                    endcase
                    // skip multiply when exponent bit clear; go to the difference once it is zero
                    if (state_reg == S_LOOP && (stat.exp_zero || !stat.exp_bit))
                    begin
                        cmd.start   = 1'b0;
                        issued_next = 1'b0;
                        state_next  = stat.exp_zero ? S_DIFF : S_SQR;
                    end
                    if (state_reg == S_INIT && stat.idx_zero)
                    begin
                        cmd.start   = 1'b0;
                        issued_next = 1'b0;
                        state_next  = S_OUT;
                    end
                end
                else if (!stat.busy)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        S_RG1:   state_next = S_RG2;
                        S_RG2:   state_next = S_INIT;
                        S_INIT:  state_next = S_LOOP;
                        S_LOOP:  state_next = S_SQR;
                        S_SQR:   state_next = S_LOOP;
                        S_DIFF:  state_next = S_FINAL;
                        default: state_next = S_OUT;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_taken) |=> result_valid)
        else $error("result dropped before transaction");
    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && issued_reg) |-> 1'b0)
        else $error("second command issued while one is outstanding");

endmodule
`default_nettype wire

FILE: hw/rtl/fibonacci_like_term_mod.sv
// Top level: g_n mod m of a Fibonacci-like sequence via 2x2 matrix powers.
//
//  channel | direction | handshake        | payload
//  in      | into      | in_valid/in_stall | fltm_in_t
//  out     | out of    | out_valid/out_stall | fltm_out_t
//  cfg     | into      | cfg_we            | cfg_data (modulus)
//
// One transaction at a time; every reduce command and every product step passes
// through the single bit-serial reducer, with 16 steps per matrix product.
// Reset clears the controller and sets modulus to 1. A modulus of 0 acts as 1.
// out_stall holds the result; no new transaction is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module fibonacci_like_term_mod
    import fltm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fltm_in_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output fltm_out_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [MOD_BITS-1:0] cfg_data
);

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] eff_mod;
    fltm_in_t            item_reg;
    fltm_cmd_t           cmd;
    fltm_stat_t          stat;
    logic                idle, in_fire, out_fire, rv;
    logic [MOD_BITS-1:0] dp_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_BITS'(1);
        else if (cfg_we)
            modulus_reg <= cfg_data;
    end

    assign eff_mod  = (modulus_reg == '0) ? MOD_BITS'(1) : modulus_reg;
    assign in_stall = !idle;
    assign in_fire  = in_valid && idle;
    assign out_fire = rv && !out_stall;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
    end

    fltm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_taken(out_fire),
        .stat(stat), .cmd(cmd), .idle(idle), .result_valid(rv)
    );

    fltm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .item(in_fire ? in_data : item_reg), .modulus(eff_mod),
        .stat(stat), .result(dp_result)
    );

    assign out_valid          = rv;
    assign out_data.bad_index = stat.idx_zero;
    // for index zero the datapath holds g1 mod m
    assign out_data.term_value = dp_result;

endmodule
`default_nettype wire
